// ===== src/tlpt_pkg.sv =====
// Shared constants, command and status codes, and control/status structs for the page table engine.
package tlpt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int IDX_W       = 10;
  localparam int DIR_ENTRIES = 1 << IDX_W;
  localparam int TBL_DEPTH   = TABLE_SLOTS * DIR_ENTRIES;
  localparam int TBL_AW      = SLOT_W + IDX_W;
  localparam int ENTRY_W     = 32;
  localparam int FLAG_W      = 12;
  localparam int FRAME_W     = ENTRY_W - FLAG_W;
  localparam int DIR_LSB     = 22;
  localparam int TBL_LSB     = 12;

  localparam int IN_DATA_W   = 80;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 48;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_MAP    = 3'd0;
  localparam cmd_t CMD_UNMAP  = 3'd1;
  localparam cmd_t CMD_SET    = 3'd2;
  localparam cmd_t CMD_CLEAR  = 3'd3;
  localparam cmd_t CMD_LOOKUP = 3'd4;
  localparam cmd_t CMD_FREE   = 3'd5;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NO_TABLE = 3'd1;
  localparam status_t ST_NO_PAGE  = 3'd2;
  localparam status_t ST_MAPPED   = 3'd3;
  localparam status_t ST_NO_SLOT  = 3'd4;

  typedef struct packed {
    logic    item_load;
    logic    cnt_clr;
    logic    dir_clr;
    logic    dir_map;
    logic    dir_free;
    logic    slot_ld;
    logic    tbl_clr;
    logic    tbl_rd;
    logic    tbl_rd_dir;
    logic    tbl_wr;
    logic    res_ld;
    logic    res_tbl;
    status_t res_status;
    logic    out_ld;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic dir_present;
    logic slot_avail;
    logic ent_present;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/tlpt_ctrl.sv =====
// Command sequencer: directory clear after reset, directory and table access steps.
module tlpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tlpt_pkg::sts_t sts,
  output tlpt_pkg::ctl_t ctl
);
  import tlpt_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIR  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TBL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_INIT: begin
        ctl.dir_clr = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.item_load = 1'b1;
          state_nxt     = S_DIR;
        end
      end
      S_DIR: begin
        state_nxt = S_FIN;
        case (sts.cmd) inside
          CMD_MAP: begin
            if (sts.dir_present) begin
              ctl.slot_ld    = 1'b1;
              ctl.tbl_rd_dir = 1'b1;
              state_nxt      = S_TBL;
            end else if (sts.slot_avail) begin
              ctl.dir_map = 1'b1;
              ctl.cnt_clr = 1'b1;
              state_nxt   = S_CLR;
            end else begin
              ctl.res_ld     = 1'b1;
              ctl.res_status = ST_NO_SLOT;
            end
          end
          CMD_UNMAP, CMD_SET, CMD_CLEAR, CMD_LOOKUP: begin
            if (sts.dir_present) begin
              ctl.slot_ld    = 1'b1;
              ctl.tbl_rd_dir = 1'b1;
              state_nxt      = S_TBL;
            end else begin
              ctl.res_ld     = 1'b1;
              ctl.res_status = ST_NO_TABLE;
            end
          end
          CMD_FREE: begin
            ctl.res_ld     = 1'b1;
            ctl.dir_free   = sts.dir_present;
            ctl.res_status = sts.dir_present ? ST_OK : ST_NO_TABLE;
          end
          default: begin
            ctl.res_ld     = 1'b1;
            ctl.res_status = ST_OK;
          end
        endcase
      end
      S_CLR: begin
        ctl.tbl_clr = 1'b1;
        if (sts.cnt_last) state_nxt = S_TRD;
      end
      S_TRD: begin
        ctl.tbl_rd = 1'b1;
        state_nxt  = S_TBL;
      end
      S_TBL: begin
        ctl.res_ld = 1'b1;
        state_nxt  = S_FIN;
        case (sts.cmd)
          CMD_MAP: begin
            ctl.tbl_wr     = !sts.ent_present;
            ctl.res_status = sts.ent_present ? ST_MAPPED : ST_OK;
          end
          default: begin
            // unmap, set, clear, lookup
            ctl.tbl_wr     = sts.ent_present && (sts.cmd != CMD_LOOKUP);
            ctl.res_tbl    = sts.ent_present;
            ctl.res_status = sts.ent_present ? ST_OK : ST_NO_PAGE;
          end
        endcase
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/tlpt_dp.sv =====
// Datapath: item registers, directory and table memories, slot pool, result and output registers.
module tlpt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tlpt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [tlpt_pkg::IN_USER_W-1:0]  in_tuser,
  input  tlpt_pkg::ctl_t                  ctl,
  output tlpt_pkg::sts_t                  sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tlpt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tlpt_pkg::*;

  // current item
  cmd_t               cmd_r;
  logic [31:0]        va_r;
  logic [31:0]        pa_r;
  logic [FLAG_W-1:0]  fl_r;

  logic [IDX_W-1:0]   dir_idx;
  logic [IDX_W-1:0]   tbl_idx;

  // directory: {present, slot}
  logic [SLOT_W:0]    dir_mem [DIR_ENTRIES];
  logic [SLOT_W:0]    dir_q;
  logic               dir_we;
  logic [IDX_W-1:0]   dir_wa;
  logic [SLOT_W:0]    dir_wd;

  logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
  logic [ENTRY_W-1:0] tbl_q;
  logic               tbl_re;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_ra;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [ENTRY_W-1:0] tbl_wd;
  logic [ENTRY_W-1:0] ent_new;
  logic [ENTRY_W-1:0] fl_ext;

  logic [IDX_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       cnt_nxt;
  logic [TABLE_SLOTS-1:0] in_use_r;
  logic [TABLE_SLOTS-1:0] in_use_nxt;
  logic [SLOT_W-1:0]      free_slot;
  logic [SLOT_W-1:0]      slot_r;

  status_t             res_status_r;
  logic [31:0]         res_trans_r;
  logic [FLAG_W-1:0]   res_flags_r;
  logic                res_inval_r;
  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign dir_idx = va_r[DIR_LSB +: IDX_W];
  assign tbl_idx = va_r[TBL_LSB +: IDX_W];
  assign fl_ext  = {{FRAME_W{1'b0}}, fl_r};

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      cmd_r <= in_tuser;
      va_r  <= in_tdata[31:0];
      pa_r  <= in_tdata[63:32];
      fl_r  <= in_tdata[64 +: FLAG_W];
    end
  end

  // shared sweep counter for directory init and table clear
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_clr)                    cnt_nxt = '0;
    else if (ctl.dir_clr || ctl.tbl_clr) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) free_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    if (ctl.dir_map)  in_use_nxt[free_slot] = 1'b1;
    if (ctl.dir_free) in_use_nxt[dir_q[SLOT_W-1:0]] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_use_r <= '0;
    else        in_use_r <= in_use_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.dir_map)      slot_r <= free_slot;
    else if (ctl.slot_ld) slot_r <= dir_q[SLOT_W-1:0];
  end

  // directory memory
  assign dir_we = ctl.dir_clr || ctl.dir_map || ctl.dir_free;
  assign dir_wa = ctl.dir_clr ? cnt_r : dir_idx;
  assign dir_wd = ctl.dir_map ? {1'b1, free_slot} : '0;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (ctl.item_load) dir_q <= dir_mem[in_tdata[DIR_LSB +: IDX_W]];
  end

  // table memory
  always_comb begin
    case (cmd_r)
      CMD_MAP:   ent_new = {pa_r[31:TBL_LSB], fl_r};
      CMD_UNMAP: ent_new = tbl_q & ~ENTRY_W'(1);
      CMD_SET:   ent_new = tbl_q | fl_ext;
      CMD_CLEAR: ent_new = tbl_q & ~fl_ext;
      default:   ent_new = tbl_q;
    endcase
  end

  assign tbl_re = ctl.tbl_rd || ctl.tbl_rd_dir;
  assign tbl_ra = ctl.tbl_rd_dir ? {dir_q[SLOT_W-1:0], tbl_idx} : {slot_r, tbl_idx};
  assign tbl_we = ctl.tbl_clr || ctl.tbl_wr;
  assign tbl_wa = ctl.tbl_clr ? {slot_r, cnt_r} : {slot_r, tbl_idx};
  assign tbl_wd = ctl.tbl_clr ? '0 : ent_new;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_q <= tbl_mem[tbl_ra];
  end

  // result
  always_ff @(posedge clk) begin
    if (ctl.res_ld) begin
      res_status_r <= ctl.res_status;
      if (ctl.res_tbl && cmd_r == CMD_LOOKUP) begin
        res_trans_r <= {tbl_q[31:TBL_LSB], va_r[TBL_LSB-1:0]};
        res_flags_r <= tbl_q[FLAG_W-1:0];
      end else begin
        res_trans_r <= '0;
        res_flags_r <= '0;
      end
      res_inval_r <= ctl.res_tbl &&
                     (cmd_r == CMD_UNMAP || cmd_r == CMD_SET || cmd_r == CMD_CLEAR);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)          out_tvalid_r <= 1'b0;
    else if (ctl.out_ld) out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) out_tdata_r <= {res_inval_r, res_flags_r, res_trans_r, res_status_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign sts.cmd         = cmd_r;
  assign sts.dir_present = dir_q[SLOT_W];
  assign sts.slot_avail  = !(&in_use_r);
  assign sts.ent_present = tbl_q[0];
  assign sts.cnt_last    = &cnt_r;
  assign sts.out_free    = !out_tvalid_r || out_tready;

`ifndef NO_ASSERTIONS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while held");
  a_map_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dir_map |-> !(&in_use_r))
    else $error("table created with no free slot");
  a_clr_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.tbl_clr && (ctl.tbl_wr || tbl_re)))
    else $error("table access during clear sweep");
  a_map_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dir_map |=> in_use_r[slot_r])
    else $error("taken slot not marked in use");
`endif

endmodule

// ===== src/two_level_page_table_manager_top.sv =====
// Top level of the two-level page table engine: sequencer plus datapath.
// Each command transfer produces one result transfer. After reset the block clears all
// 1024 directory entries (in_tready low) before it takes the first command. The
// directory memory is read at the input transfer itself. The table memory read, the
// table write and result capture step and the output register load follow in order;
// the load waits until the output register is free, and out_tvalid rises after it.
// Commands that end at the directory step skip the two table steps. A map that has
// to create a second-level table first sweeps every entry of it clear, then reads it.
// Commands are processed one at a time. The output register lets the next command be
// taken while a result waits downstream.
module two_level_page_table_manager_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] virt_addr, [63:32] phys_addr, [75:64] flag_bits, [79:76] zero
  input  logic [tlpt_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [tlpt_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] status, [34:3] translated, [46:35] page_flags, [47] invalidate
  output logic [tlpt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tlpt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tlpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/two_level_page_table_manager_top_test.sv =====
// Self-checking stream testbench for the two-level page table engine.
module two_level_page_table_manager_top_test;
  import tlpt_pkg::*;

  // command codes the block ignores
  localparam cmd_t CMD_RSVD6 = 3'd6;
  localparam cmd_t CMD_RSVD7 = 3'd7;

  localparam int RAND_ITEMS   = 2000;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_ROWS       = 26;
  localparam int N_DIRS       = 20;
  localparam int N_TIXS       = 12;

  // packed in the same order as out_tdata
  typedef struct packed {
    logic              invalidate;
    logic [FLAG_W-1:0] page_flags;
    logic [31:0]       translated;
    status_t           status;
  } walk_res_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [31:0]       va;
    logic [31:0]       pa;
    logic [FLAG_W-1:0] fl;
    logic              fixed;
    status_t           st;
    logic [31:0]       tr;
    logic [FLAG_W-1:0] pf;
    logic              iv;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow page tables
  bit                    dir_present [DIR_ENTRIES];
  logic [SLOT_W-1:0]     dir_slot [DIR_ENTRIES];
  bit [TABLE_SLOTS-1:0]  slot_used;
  logic [ENTRY_W-1:0]    tbl_mem [TABLE_SLOTS][DIR_ENTRIES];

  walk_res_t pending_walks [$];
  int walk_errors;
  int results_seen;
  int cmds_sent;
  int tables_built;
  int slot_misses;
  int snd_idle;
  int rcv_idle;

  logic [IDX_W-1:0] dir_pool [N_DIRS];
  logic [IDX_W-1:0] tix_pool [N_TIXS];

  plan_row_t plan [N_ROWS] = '{
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    '{CMD_UNMAP,  32'hffff_ffff, 32'h0000_0000, 12'h000, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    '{CMD_SET,    32'h1234_5678, 32'h0000_0000, 12'hfff, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    '{CMD_CLEAR,  32'h8765_4321, 32'h0000_0000, 12'hfff, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    '{CMD_FREE,   32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    '{CMD_RSVD6,  32'hffff_ffff, 32'hffff_ffff, 12'hfff, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_RSVD7,  32'hffff_ffff, 32'hffff_ffff, 12'hfff, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_MAP,    32'hffff_ffff, 32'hffff_ffff, 12'hfff, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 12'h000, 1'b1, ST_OK,
      32'hffff_ffff, 12'hfff, 1'b0},
    '{CMD_MAP,    32'hffff_ffff, 32'h0000_0000, 12'h001, 1'b1, ST_MAPPED, 32'h0, 12'h000, 1'b0},
    '{CMD_UNMAP,  32'hffff_f123, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 12'h000, 1'b1},
    '{CMD_LOOKUP, 32'hffff_f000, 32'h0000_0000, 12'h000, 1'b1, ST_NO_PAGE, 32'h0, 12'h000, 1'b0},
    // page not present: remap is allowed
    '{CMD_MAP,    32'hffff_f000, 32'h0000_0000, 12'h001, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_SET,    32'hffff_f000, 32'h0000_0000, 12'h800, 1'b1, ST_OK, 32'h0, 12'h000, 1'b1},
    '{CMD_LOOKUP, 32'hffff_f7ff, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_MAP,    32'h0000_0000, 32'h1234_5abc, 12'h001, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_SET,    32'h0000_0fff, 32'h0000_0000, 12'h0f0, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'h0000_0abc, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    // clearing all flags drops the present bit too
    '{CMD_CLEAR,  32'h0000_0000, 32'h0000_0000, 12'hfff, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_NO_PAGE, 32'h0, 12'h000, 1'b0},
    '{CMD_FREE,   32'hffff_ffff, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 12'h000, 1'b1, ST_NO_TABLE, 32'h0, 12'h000, 1'b0},
    // reuses the freed slot, which must come back cleared
    '{CMD_MAP,    32'h0040_0000, 32'hffff_f000, 12'h801, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'h007f_f000, 32'h0000_0000, 12'h000, 1'b1, ST_NO_PAGE, 32'h0, 12'h000, 1'b0},
    '{CMD_LOOKUP, 32'h0040_0555, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 12'h000, 1'b0},
    '{CMD_FREE,   32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 12'h000, 1'b0}
  };

  two_level_page_table_manager_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow tables and returns the result it should give.
  function automatic walk_res_t run_page_cmd(cmd_t c, logic [31:0] va, logic [31:0] pa,
                                             logic [FLAG_W-1:0] fl);
    walk_res_t          r;
    logic [IDX_W-1:0]   d;
    logic [IDX_W-1:0]   t;
    logic [ENTRY_W-1:0] ent;
    int                 s;
    int                 i;
    r = '0;
    d = va[31:DIR_LSB];
    t = va[DIR_LSB-1:TBL_LSB];
    s = -1;
    case (c) inside
      CMD_MAP: begin
        if (!dir_present[d]) begin
          for (i = TABLE_SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) s = i;
          if (s < 0) begin
            r.status = ST_NO_SLOT;
            slot_misses++;
            return r;
          end
          slot_used[s] = 1'b1;
          for (i = 0; i < DIR_ENTRIES; i++) tbl_mem[s][i] = '0;
          dir_slot[d]    = SLOT_W'(s);
          dir_present[d] = 1'b1;
          tables_built++;
        end
        ent = tbl_mem[dir_slot[d]][t];
        if (ent[0]) r.status = ST_MAPPED;
        else tbl_mem[dir_slot[d]][t] = {pa[31:TBL_LSB], fl};
      end
      CMD_UNMAP, CMD_SET, CMD_CLEAR, CMD_LOOKUP: begin
        if (!dir_present[d]) begin
          r.status = ST_NO_TABLE;
        end else begin
          ent = tbl_mem[dir_slot[d]][t];
          if (!ent[0]) begin
            r.status = ST_NO_PAGE;
          end else begin
            case (c)
              CMD_UNMAP: ent[0] = 1'b0;
              CMD_SET:   ent[FLAG_W-1:0] = ent[FLAG_W-1:0] | fl;
              CMD_CLEAR: ent[FLAG_W-1:0] = ent[FLAG_W-1:0] & ~fl;
              default: begin
                r.translated = {ent[31:TBL_LSB], va[TBL_LSB-1:0]};
                r.page_flags = ent[FLAG_W-1:0];
              end
            endcase
            r.invalidate = (c != CMD_LOOKUP);
            tbl_mem[dir_slot[d]][t] = ent;
          end
        end
      end
      CMD_FREE: begin
        if (!dir_present[d]) begin
          r.status = ST_NO_TABLE;
        end else begin
          slot_used[dir_slot[d]] = 1'b0;
          dir_present[d]         = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_result(walk_res_t got);
    walk_res_t want;
    if (pending_walks.size() == 0) begin
      $error("result with nothing pending: %h", got);
      walk_errors++;
      return;
    end
    want = pending_walks.pop_front();
    results_seen++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      walk_errors++;
    end
    if (got.translated !== want.translated) begin
      $error("translated: expected %h, got %h", want.translated, got.translated);
      walk_errors++;
    end
    if (got.page_flags !== want.page_flags) begin
      $error("page_flags: expected %h, got %h", want.page_flags, got.page_flags);
      walk_errors++;
    end
    if (got.invalidate !== want.invalidate) begin
      $error("invalidate: expected %0d, got %0d", want.invalidate, got.invalidate);
      walk_errors++;
    end
  endfunction

  // One command transfer; the expectation is either the typed one or the predicted one.
  task automatic send_cmd(cmd_t c, logic [31:0] va, logic [31:0] pa, logic [FLAG_W-1:0] fl,
                          bit fixed, walk_res_t fixed_res);
    walk_res_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {4'b0, fl, pa, va};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = run_page_cmd(c, va, pa, fl);
    pending_walks.push_back(fixed ? fixed_res : r);
    cmds_sent++;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int                i;
    int                phase;
    int                pick;
    cmd_t              c;
    logic [31:0]       va;
    logic [31:0]       pa;
    logic [FLAG_W-1:0] fl;
    walk_res_t         fixed_res;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    rst_n      = 1'b0;
    snd_idle   = 17;
    rcv_idle   = 55;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_ROWS; i++) begin
      fixed_res.status     = plan[i].st;
      fixed_res.translated = plan[i].tr;
      fixed_res.page_flags = plan[i].pf;
      fixed_res.invalidate = plan[i].iv;
      send_cmd(plan[i].cmd, plan[i].va, plan[i].pa, plan[i].fl, plan[i].fixed, fixed_res);
    end

    // a few more directories than slots, so the pool runs dry now and then
    for (i = 0; i < N_DIRS; i++) dir_pool[i] = IDX_W'($urandom);
    for (i = 0; i < N_TIXS; i++) tix_pool[i] = IDX_W'($urandom);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle = 17; rcv_idle = 55; end
        1: begin snd_idle = 55; rcv_idle = 17; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (i = 0; i < (RAND_ITEMS + 2) / 3; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 26) c = CMD_MAP;
        else if (pick < 36) c = CMD_UNMAP;
        else if (pick < 48) c = CMD_SET;
        else if (pick < 58) c = CMD_CLEAR;
        else if (pick < 94) c = CMD_LOOKUP;
        else if (pick < 97) c = CMD_FREE;
        else c = ($urandom_range(0, 1) != 0) ? CMD_RSVD7 : CMD_RSVD6;
        if ($urandom_range(0, 99) < 4) va = $urandom;
        else va = {dir_pool[$urandom_range(0, N_DIRS - 1)],
                   tix_pool[$urandom_range(0, N_TIXS - 1)], 12'($urandom)};
        pa = $urandom;
        fl = FLAG_W'($urandom);
        if (c == CMD_MAP) fl[0] = ($urandom_range(0, 99) < 85);
        if (c == CMD_CLEAR && $urandom_range(0, 99) < 80) fl[0] = 1'b0;
        send_cmd(c, va, pa, fl, 1'b0, '0);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending_walks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands under three handshake pacing modes, %0d results checked.",
             cmds_sent, results_seen);
    $display("Built %0d second-level tables, %0d maps refused for an empty slot pool.",
             tables_built, slot_misses);
    if (walk_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
